[rtl/pebuf_pkg.sv]
// Shared types and constants for the priority evicting event buffer.
`default_nettype none

package pebuf_pkg;

  localparam int PRIO_W        = 8;
  localparam int PAYLOAD_W     = 32;
  localparam int STAMP_W       = 32;
  localparam int CAPACITY_DEF  = 16;

  localparam logic [1:0] MODE_RECORD  = 2'd0;
  localparam logic [1:0] MODE_PEEK    = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  typedef struct packed {
    logic [1:0]           mode;
    logic [PRIO_W-1:0]    event_priority;
    logic [PAYLOAD_W-1:0] event_payload;
  } in_item_t;

  typedef struct packed {
    logic                 ok;
    logic [PRIO_W-1:0]    out_priority;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [STAMP_W-1:0]   out_sequence;
    logic [STAMP_W-1:0]   out_dropped_before;
  } out_item_t;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
    logic [STAMP_W-1:0]   sequence_num;
    logic [STAMP_W-1:0]   drop_stamp;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] lowest;
  } best_t;

endpackage

`default_nettype wire

[rtl/priority_evicting_event_buffer_unit.sv]
// Top level of the priority evicting event buffer.
`default_nettype none

// Bounded FIFO of stamped events held in a row of CAPACITY slot cells. Peek, read,
// discard and a record into a buffer that is not full take one transaction and
// present the result in the output register in the next cycle. A record into a full
// buffer runs the victim search through the registered compare chain of the cells,
// one cell per cycle, and delivers its result once the scan has covered the chain
// and the output is free; the eviction shift and the append happen in the same cycle.
// One item is in work at a time, and a new item is taken while the previous result
// is being taken. Entries hold no reset value; only filled slots are ever returned.
module priority_evicting_event_buffer_unit
  import pebuf_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire           out_stall,
  output out_item_t     out_data
);

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0]         state_r, state_nxt;
  logic [FILL_W-1:0]  cnt_r, cnt_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [STAMP_W-1:0] seq_r, seq_nxt;
  logic [STAMP_W-1:0] drop_r, drop_nxt;
  entry_t             hold_r, hold_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               in_accept;
  logic               out_free;
  logic [STAMP_W-1:0] drop_inc;
  logic               remove_en;
  logic [IDX_W-1:0]   rm_pos;
  logic               append_en;
  logic [FILL_W-1:0]  tgt;
  entry_t             new_entry;
  logic               out_load;

  entry_t             entry_q [CAPACITY];
  best_t              best_q  [CAPACITY];
  logic [IDX_W-1:0]   idx_q   [CAPACITY];
  cell_ctl_t          ctl     [CAPACITY];
  best_t              best_head;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign drop_inc  = (drop_r == '1) ? drop_r : drop_r + STAMP_W'(1);
  assign tgt       = remove_en ? fill_r - FILL_W'(1) : fill_r;

  assign best_head.found  = 1'b0;
  assign best_head.lowest = hold_r.prio;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    seq_nxt      = seq_r;
    drop_nxt     = drop_r;
    hold_nxt     = hold_r;
    remove_en    = 1'b0;
    rm_pos       = '0;
    append_en    = 1'b0;
    new_entry    = hold_r;
    out_load     = 1'b0;
    out_data_nxt = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data.mode)
            MODE_RECORD: begin
              new_entry.prio         = in_data.event_priority;
              new_entry.payload      = in_data.event_payload;
              new_entry.sequence_num = seq_r;
              new_entry.drop_stamp   = drop_r;
              if (seq_r == '0) begin
                // sequence exhausted: refuse and count
                drop_nxt = drop_inc;
                out_load = 1'b1;
              end else if (fill_r != FILL_W'(CAPACITY)) begin
                seq_nxt         = seq_r + STAMP_W'(1);
                append_en       = 1'b1;
                fill_nxt        = fill_r + FILL_W'(1);
                out_data_nxt.ok = 1'b1;
                out_load        = 1'b1;
              end else begin
                seq_nxt   = seq_r + STAMP_W'(1);
                hold_nxt  = new_entry;
                cnt_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            MODE_PEEK, MODE_READ, MODE_DISCARD: begin
              out_load = 1'b1;
              if (fill_r != '0) begin
                out_data_nxt.ok = 1'b1;
                if (in_data.mode != MODE_DISCARD) begin
                  out_data_nxt.out_priority       = entry_q[0].prio;
                  out_data_nxt.out_payload        = entry_q[0].payload;
                  out_data_nxt.out_sequence       = entry_q[0].sequence_num;
                  out_data_nxt.out_dropped_before = entry_q[0].drop_stamp;
                end
                if (in_data.mode != MODE_PEEK) begin
                  remove_en = 1'b1;
                  fill_nxt  = fill_r - FILL_W'(1);
                end
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_r != FILL_W'(CAPACITY)) begin
          cnt_nxt = cnt_r + FILL_W'(1);
        end else if (out_free) begin
          state_nxt = ST_IDLE;
          out_load  = 1'b1;
          drop_nxt  = drop_inc;
          if (best_q[CAPACITY-1].found) begin
            // evict the victim, append at the top; eviction counts before stamping
            remove_en            = 1'b1;
            rm_pos               = idx_q[CAPACITY-1];
            append_en            = 1'b1;
            new_entry.drop_stamp = drop_inc;
            out_data_nxt.ok      = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t           next_entry;
    best_t            best_in;
    logic [IDX_W-1:0] idx_in;

    assign ctl[i].shift = remove_en && (IDX_W'(i) >= rm_pos);
    assign ctl[i].load  = append_en && (FILL_W'(i) == tgt);

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry_q[i];
    end else begin : g_mid
      assign next_entry = entry_q[i+1];
    end

    if (i == 0) begin : g_head
      assign best_in = best_head;
      assign idx_in  = '0;
    end else begin : g_link
      assign best_in = best_q[i-1];
      assign idx_in  = idx_q[i-1];
    end

    pebuf_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_entry  (new_entry),
      .next_entry (next_entry),
      .best_in    (best_in),
      .idx_in     (idx_in),
      .entry_q    (entry_q[i]),
      .best_out   (best_q[i]),
      .idx_out    (idx_q[i])
    );
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      seq_r       <= STAMP_W'(1);
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      seq_r       <= seq_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> fill_r == FILL_W'(CAPACITY))
    else $error("victim search while buffer not full");

  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.mode != MODE_RECORD |=> out_valid_r)
    else $error("missing result for a queue read operation");

  a_seq_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == '0 |=> seq_r == '0)
    else $error("exhausted sequence counter restarted");
`endif

endmodule

`default_nettype wire

[rtl/pebuf_cell.sv]
// One buffer slot: holds an entry and one stage of the victim search chain.
`default_nettype none

module pebuf_cell
  import pebuf_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  wire              clk,
  input  wire cell_ctl_t   ctl,
  input  wire entry_t      new_entry,
  input  wire entry_t      next_entry,
  input  wire best_t       best_in,
  input  wire [IDX_W-1:0]  idx_in,
  output entry_t           entry_q,
  output best_t            best_out,
  output logic [IDX_W-1:0] idx_out
);

  entry_t           entry_r;
  best_t            best_r;
  best_t            best_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             lower;

  // Append wins over shift; shift pulls the upper neighbor down.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= new_entry;
    end else if (ctl.shift) begin
      entry_r <= next_entry;
    end
  end

  // Strictly lower keeps the first of equal minima.
  always_comb begin
    lower = entry_r.prio < best_in.lowest;
    if (lower) begin
      best_nxt.found  = 1'b1;
      best_nxt.lowest = entry_r.prio;
      idx_nxt         = IDX_W'(IDX);
    end else begin
      best_nxt = best_in;
      idx_nxt  = idx_in;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    idx_r  <= idx_nxt;
  end

  assign entry_q  = entry_r;
  assign best_out = best_r;
  assign idx_out  = idx_r;

endmodule

`default_nettype wire
